// ===== rtl/indexed_point_list_macros.svh =====
// Assertion macros for the indexed point list RTL.
// Used by indexed_point_list.sv; expects clk and rst_n in scope.
`ifndef INDEXED_POINT_LIST_MACROS_SVH
`define INDEXED_POINT_LIST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IPL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_point_list: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IPL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_point_list: next-cycle check failed");

`endif

// ===== rtl/ipl_pkg.sv =====
// Shared types, constants and coordinate conversions for the indexed point list.
// No dependencies; used by indexed_point_list and the testbench.
package ipl_pkg;

    localparam int CAPACITY    = 64;
    localparam int COORD_BITS  = 16;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int POS_W       = 6;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int COUNT_OUT_W = 7;
    localparam int ENTRY_W     = 2 * COORD_BITS;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_GET    = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]        operation;
        logic [POS_W-1:0]  position;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } ipl_cmd_t;

    typedef struct packed {
        logic [1:0]             status;
        logic signed [15:0]     found_x;
        logic signed [15:0]     found_y;
        logic [COUNT_OUT_W-1:0] entry_count;
    } ipl_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_REM  = 4'b0100,
        S_GET  = 4'b1000
    } state_t;

    // 16-bit input coordinate to stored width (sign-extend, keep low bits)
    function automatic logic [COORD_BITS-1:0] to_store(logic signed [15:0] v);
        logic signed [COORD_BITS+15:0] w;
        w = (COORD_BITS + 16)'(v);
        return w[COORD_BITS-1:0];
    endfunction

    // stored coordinate to 16-bit output (sign-extend, keep low bits)
    function automatic logic signed [15:0] to_out(logic [COORD_BITS-1:0] v);
        logic signed [COORD_BITS+15:0] w;
        w = (COORD_BITS + 16)'($signed(v));
        return w[15:0];
    endfunction

endpackage

// ===== rtl/ipl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ipl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/indexed_point_list.sv =====
// indexed_point_list: ordered list of points held in one RAM ({x, y} per entry).
// Push, clear, rejected ops, appends and last-entry removes answer from idle; a get
// reads RAM in S_GET; other inserts/removes shift in S_INS/S_REM, one entry per cycle.
// Throughput: one command at a time; the next beat is taken at the earliest on the edge
// the previous response beat is taken. The single RAM write port sets the shift rate.
// Reset clears the count, sequencer and response valid; RAM contents are left as is.
`include "indexed_point_list_macros.svh"

module indexed_point_list import ipl_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  ipl_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ipl_rsp_t rsp
);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;     // next RAM address to write
    logic [ADDR_W-1:0]     stop_reg, stop_next;   // last address written by a shift
    logic [COORD_BITS-1:0] px_reg, px_next;       // point waiting for insert
    logic [COORD_BITS-1:0] py_reg, py_next;
    ipl_rsp_t              rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]    rd_data;

    logic                  accept;
    logic                  rsp_free;
    logic                  load_rsp;
    logic                  full;
    logic                  get_ok;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [ADDR_W-1:0]     pos_addr;
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;

    ipl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Response register frees up on the same edge its beat is taken.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != S_IDLE) || !rsp_free;
    assign accept    = cmd_valid && !cmd_stall;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext  = CMP_W'(cmd.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_addr = ADDR_W'(cmd.position);
    assign in_x     = to_store(cmd.point_x);
    assign in_y     = to_store(cmd.point_y);
    assign get_ok   = (cmd.operation == OP_GET) && (pos_ext < cnt_ext);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        stop_next  = stop_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_data;
        rd_addr    = ptr_reg;
        load_rsp   = 1'b0;
        rsp_next   = '{status: ST_OK, found_x: '0, found_y: '0, entry_count: '0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_rsp = 1'b1;
                    unique case (cmd.operation)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ADDR_W'(count_reg);
                                wr_data    = {in_x, in_y};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                rsp_next.status = ST_BAD_POS;
                            end
                            else if (full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                if (pos_ext == cnt_ext)
                                begin
                                    // append: no entries to move
                                    wr_en   = 1'b1;
                                    wr_addr = pos_addr;
                                    wr_data = {in_x, in_y};
                                end
                                else
                                begin
                                    // move entries up from the top, point goes in last
                                    load_rsp   = 1'b0;
                                    rd_addr    = ADDR_W'(count_reg - CNT_W'(1));
                                    ptr_next   = ADDR_W'(count_reg);
                                    stop_next  = pos_addr;
                                    px_next    = in_x;
                                    py_next    = in_y;
                                    state_next = S_INS;
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                rsp_next.status = ST_BAD_POS;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (pos_ext != cnt_ext - CMP_W'(1))
                                begin
                                    // move entries down, starting at the removed slot
                                    load_rsp   = 1'b0;
                                    rd_addr    = pos_addr + ADDR_W'(1);
                                    ptr_next   = pos_addr;
                                    stop_next  = ADDR_W'(count_reg - CNT_W'(2));
                                    state_next = S_REM;
                                end
                            end
                        end
                        OP_GET:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                rsp_next.status = ST_BAD_POS;
                            end
                            else
                            begin
                                load_rsp   = 1'b0;
                                rd_addr    = pos_addr;
                                state_next = S_GET;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused codes: no change, status ok
                        end
                    endcase
                end
            end
            S_INS:
            begin
                wr_en = 1'b1;
                if (ptr_reg == stop_reg)
                begin
                    wr_data    = {px_reg, py_reg};
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // rd_data holds entry ptr-1; fetch ptr-2 for the next cycle
                    rd_addr  = ptr_reg - ADDR_W'(2);
                    ptr_next = ptr_reg - ADDR_W'(1);
                end
            end
            S_REM:
            begin
                // rd_data holds entry ptr+1; fetch ptr+2 for the next cycle
                wr_en   = 1'b1;
                rd_addr = ptr_reg + ADDR_W'(2);
                if (ptr_reg == stop_reg)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_GET:
            begin
                load_rsp         = 1'b1;
                rsp_next.found_x = to_out(rd_data[ENTRY_W-1:COORD_BITS]);
                rsp_next.found_y = to_out(rd_data[COORD_BITS-1:0]);
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next.entry_count = COUNT_OUT_W'(count_next);
    end

    always_comb
    begin
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        stop_reg <= stop_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------- checks
    // a command beat is only taken by an idle sequencer
    `IPL_ASSERT_NOW(a_accept_idle, accept, state_reg == S_IDLE)
    // a new response never overwrites one still waiting
    `IPL_ASSERT_NOW(a_no_rsp_overwrite, load_rsp, rsp_free)
    // count stays within capacity
    `IPL_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // a good get moves to S_GET in the next cycle to wait for RAM data
    `IPL_ASSERT_NEXT(a_get_reads, accept && get_ok, state_reg == S_GET)

endmodule

// ===== dv/indexed_point_list_tb.sv =====
// Self-checking testbench for indexed_point_list: list operations in, one response per beat.
// Depends on ipl_pkg (command/response structs, op and status codes) and the RTL top.
`default_nettype none

module indexed_point_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipl_pkg::*;

    // Codes the block must treat as no-ops
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1350;
    // Slowest legal beat: an insert at 0 with CAPACITY - 1 held, a long receiver stall and a
    // sender gap; the limit allows for every beat being that slow, several times over.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Quiet time after the last response: longer than the deepest shift
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_READ, MIX_EVEN} op_mix_t;

    // Shadow copy of the point list plus the queue of responses it predicts
    class point_list_shadow;
        logic [COORD_BITS-1:0] xs [CAPACITY];
        logic [COORD_BITS-1:0] ys [CAPACITY];
        int held;
        ipl_rsp_t pending_rsp [$];
        int mismatch_count;

        function new();
            held = 0;
            mismatch_count = 0;
        endfunction

        // Apply one accepted command beat and queue the response it must produce
        function void apply_command(ipl_cmd_t c);
            ipl_rsp_t r;
            logic [COORD_BITS-1:0] px;
            logic [COORD_BITS-1:0] py;
            int p;
            int i;
            r = '0;
            r.status = ST_OK;
            p = int'(c.position);
            px = COORD_BITS'(c.point_x);
            py = COORD_BITS'(c.point_y);
            case (c.operation)
                OP_PUSH:
                    if (held >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        xs[held] = px;
                        ys[held] = py;
                        held++;
                    end
                OP_INSERT:
                    // position is checked before fullness
                    if (p > held)
                        r.status = ST_BAD_POS;
                    else if (held >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        for (i = held; i > p; i--)
                        begin
                            xs[i] = xs[i-1];
                            ys[i] = ys[i-1];
                        end
                        xs[p] = px;
                        ys[p] = py;
                        held++;
                    end
                OP_REMOVE:
                    if (p >= held)
                        r.status = ST_BAD_POS;
                    else
                    begin
                        for (i = p; i + 1 < held; i++)
                        begin
                            xs[i] = xs[i+1];
                            ys[i] = ys[i+1];
                        end
                        held--;
                    end
                OP_GET:
                    if (p >= held)
                        r.status = ST_BAD_POS;
                    else
                    begin
                        r.found_x = 16'($signed(xs[p]));
                        r.found_y = 16'($signed(ys[p]));
                    end
                OP_CLEAR:
                    held = 0;
                default:
                    ;
            endcase
            r.entry_count = COUNT_OUT_W'(held);
            pending_rsp.push_back(r);
        endfunction

        function void flag_field(string field, int want, int got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        endfunction

        // Compare one accepted response beat with the oldest prediction
        function void check_response(ipl_rsp_t got);
            ipl_rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response with none expected, expected nothing, actual %p",
                         $time, got);
                mismatch_count++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
                flag_field("status", int'(want.status), int'(got.status));
            if (got.found_x !== want.found_x)
                flag_field("found_x", int'(want.found_x), int'(got.found_x));
            if (got.found_y !== want.found_y)
                flag_field("found_y", int'(want.found_y), int'(got.found_y));
            if (got.entry_count !== want.entry_count)
                flag_field("entry_count", int'(want.entry_count), int'(got.entry_count));
        endfunction
    endclass

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    ipl_cmd_t cmd       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    ipl_rsp_t rsp;

    point_list_shadow shadow = new();
    int cycle_count = 0;

    indexed_point_list DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard: a hang or a lost response ends here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("indexed_point_list test failed");
        $finish;
    end

    // Receiver back-pressure. The style is redrawn after a random stretch: open,
    // light random, heavy random, or a fixed duty pattern, so stalls land on
    // every cycle of a long shift as well as on ops answered from idle.
    int stall_style = 0;
    int style_left  = 0;
    int stall_phase = 0;
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(50, 300);
        end
        style_left--;
        stall_phase++;
        case (stall_style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= ((stall_phase % 7) < 3);
        endcase
    end

    // Response monitor: every accepted beat is checked against the shadow
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            shadow.check_response(rsp);
    end

    // Present one command beat and hold it until the block takes it.
    // Sampling right after the edge sees pre-edge values, so the test of
    // cmd_stall matches the handshake the block saw.
    task automatic send_cmd(input ipl_cmd_t beat);
        cmd_valid <= 1'b1;
        cmd       <= beat;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        shadow.apply_command(beat);
    endtask

    task automatic send_op(input logic [2:0] op, input int pos,
                           input logic signed [15:0] x, input logic signed [15:0] y);
        ipl_cmd_t beat;
        beat.operation = op;
        beat.position  = POS_W'(pos);
        beat.point_x   = x;
        beat.point_y   = y;
        send_cmd(beat);
    endtask

    // Short hand-picked run: empty-list errors, coordinate extremes, insert at
    // front and at the end, out-of-range positions, removes from the middle,
    // the end and the front, unused opcodes and clear.
    task automatic run_directed();
        send_op(OP_GET,    0,  16'sh0000, 16'sh0000);  // get on empty list
        send_op(OP_REMOVE, 0,  16'sh0000, 16'sh0000);  // remove on empty list
        send_op(OP_INSERT, 1,  16'sh1234, 16'sh5678);  // insert past the end
        send_op(OP_PUSH,   0,  16'sh7FFF, 16'sh8000);
        send_op(OP_PUSH,   63, 16'sh8000, 16'sh7FFF);
        send_op(OP_INSERT, 0,  16'shFFFF, 16'sh0000);  // insert at front
        send_op(OP_INSERT, 3,  16'sh0000, 16'shFFFF);  // insert at count appends
        send_op(OP_INSERT, 63, 16'sh0001, 16'sh0001);  // far past the end
        send_op(OP_GET,    0,  16'sh0000, 16'sh0000);
        send_op(OP_GET,    1,  16'shFFFF, 16'shFFFF);
        send_op(OP_GET,    2,  16'sh0000, 16'sh0000);
        send_op(OP_GET,    3,  16'sh0000, 16'sh0000);
        send_op(OP_GET,    4,  16'sh0000, 16'sh0000);  // one past the last entry
        send_op(OP_GET,    63, 16'sh0000, 16'sh0000);
        send_op(OP_REMOVE, 1,  16'sh0000, 16'sh0000);  // middle
        send_op(OP_REMOVE, 2,  16'sh0000, 16'sh0000);  // last
        send_op(OP_REMOVE, 0,  16'sh0000, 16'sh0000);  // first
        send_op(OP_GET,    0,  16'sh0000, 16'sh0000);
        send_op(OP_SPARE_LO,         63, 16'shFFFF, 16'shFFFF);
        send_op(OP_SPARE_LO + 3'd1,  0,  16'sh7FFF, 16'sh8000);
        send_op(OP_SPARE_HI,         21, 16'sh5555, 16'shAAAA);
        send_op(OP_CLEAR,  63, 16'shFFFF, 16'shFFFF);
        send_op(OP_GET,    0,  16'sh0000, 16'sh0000);  // nothing left after clear
        send_op(OP_PUSH,   0,  16'sh0042, 16'sh8001);
        send_op(OP_GET,    0,  16'sh0000, 16'sh0000);
    endtask

    // Weighted op choice per mix. Grow phases fill the list to capacity and keep
    // pushing into it; clear is kept out of them so they get there.
    function automatic logic [2:0] pick_op(op_mix_t mix);
        int roll;
        roll = $urandom_range(0, 999);
        if (roll < 5)
            return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if (roll < 12 && mix != MIX_GROW)
            return OP_CLEAR;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                return roll < 45 ? OP_PUSH : roll < 80 ? OP_INSERT :
                       roll < 90 ? OP_REMOVE : OP_GET;
            MIX_SHRINK:
                return roll < 15 ? OP_PUSH : roll < 30 ? OP_INSERT :
                       roll < 75 ? OP_REMOVE : OP_GET;
            MIX_READ:
                return roll < 20 ? OP_PUSH : roll < 35 ? OP_INSERT :
                       roll < 50 ? OP_REMOVE : OP_GET;
            default:
                return roll < 25 ? OP_PUSH : roll < 50 ? OP_INSERT :
                       roll < 75 ? OP_REMOVE : OP_GET;
        endcase
    endfunction

    // Mostly legal positions for the current fill, the rest anywhere in the field
    function automatic int pick_position(logic [2:0] op);
        int top;
        if ($urandom_range(0, 9) < 2)
            return $urandom_range(0, 63);
        top = (op == OP_INSERT) ? shadow.held : shadow.held - 1;
        if (top < 0)
            return 0;
        if (top > 63)
            top = 63;
        return $urandom_range(0, top);
    endfunction

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random part: phases of one op mix, sent in bursts with random gaps, and
    // now and then a run of bursts with no gap at all.
    task automatic run_random(input int total);
        int sent;
        int mix_left;
        int burst;
        int gap;
        int steady_bursts;
        op_mix_t mix;
        logic [2:0] op;
        sent = 0;
        mix_left = 0;
        steady_bursts = 0;
        mix = MIX_EVEN;
        while (sent < total)
        begin
            if (mix_left <= 0)
            begin
                mix = op_mix_t'($urandom_range(0, 3));
                mix_left = $urandom_range(60, 250);
            end
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < total)
            begin
                op = pick_op(mix);
                send_op(op, pick_position(op), pick_coord(), pick_coord());
                burst--;
                sent++;
                mix_left--;
            end
            if (steady_bursts == 0 && $urandom_range(0, 5) == 0)
                steady_bursts = $urandom_range(3, 10);
            if (steady_bursts > 0)
            begin
                steady_bursts--;
                gap = 0;
            end
            else
                gap = $urandom_range(1, 6);
            if (gap > 0 && sent < total)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_ITEMS);
        cmd_valid <= 1'b0;

        // Wait for the last response, then give a stray beat time to show up
        while (shadow.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.mismatch_count == 0)
            $display("indexed_point_list test passed");
        else
            $display("indexed_point_list test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/ipl_pkg.sv
rtl/ipl_ram.sv
rtl/indexed_point_list.sv
dv/indexed_point_list_tb.sv
